// ===== src/shb_pkg.sv =====
// shb_pkg: shared types and constants of the spread histogram binner
// payload structs, mode/status/register codes and the divider result struct
// no dependencies
package shb_pkg;

    localparam int POS_W    = 32;
    localparam int WEIGHT_W = 24;
    localparam int IDX_OUT_W = 12;
    localparam int SUM_W    = 40;
    localparam int SIZE_W   = 32;
    localparam int SPREAD_W = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [SUM_W-1:0]     SUM_MAX        = {SUM_W{1'b1}};
    localparam logic [IDX_OUT_W-1:0] CENTER_MAX     = {IDX_OUT_W{1'b1}};
    localparam logic [SIZE_W-1:0]    BIN_SIZE_RESET = 32'd131072;
    localparam logic [SPREAD_W-1:0]  BIN_SPREAD_RESET = 4'd1;

    localparam logic [1:0] MODE_ADD      = 2'd0;
    localparam logic [1:0] MODE_READ     = 2'd1;
    localparam logic [1:0] MODE_READ_CLR = 2'd2;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_DROP = 2'd1;
    localparam logic [1:0] STAT_SAT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_BIN_SIZE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_SPREAD = 1'd1;

    typedef struct packed {
        logic [1:0]           mode;
        logic [POS_W-1:0]     peak_position;
        logic [WEIGHT_W-1:0]  peak_weight;
        logic [IDX_OUT_W-1:0] bin_index;
    } shb_in_t;

    typedef struct packed {
        logic [SUM_W-1:0]     bin_value;
        logic [IDX_OUT_W-1:0] center_bin;
        logic [1:0]           status;
    } shb_out_t;

    typedef struct packed {
        logic [POS_W-1:0] quotient;
        logic             exact;
    } shb_div_res_t;

endpackage

// ===== src/spread_histogram_binner_core.sv =====
// spread_histogram_binner_core: weighted histogram with neighbor spread
// top level: control sequencer, bin update pipeline, config registers
// depends on shb_pkg, shb_divider, shb_ram
//
// After reset the block sweeps the bin store to zero with s_ready low;
// configuration writes are taken during the sweep. An add transfer first runs
// the bit-serial divider, then one read-modify-write per bin of the spread
// window through the single-port-pair store, one bin per cycle. Read and
// read-and-clear transfers pass through the RDW and PUSH states.
// One item is in flight at a time; the output register lets the
// next transfer be accepted while a result still waits on m_ready.
module spread_histogram_binner_core #(
    parameter int NUM_BINS   = 4096,
    parameter int MAX_SPREAD = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  shb_pkg::shb_in_t                s_payload,
    output logic                            m_valid,
    input  logic                            m_ready,
    output shb_pkg::shb_out_t               m_payload,
    input  logic                            cfg_we,
    input  logic [shb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [shb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import shb_pkg::*;

    localparam int IDX_W = $clog2(NUM_BINS);
    localparam int SPR_W = $clog2(MAX_SPREAD + 2);
    localparam logic [32:0]      NUM_BINS_W = 33'(NUM_BINS);
    localparam logic [IDX_W-1:0] LAST_BIN   = IDX_W'(NUM_BINS - 1);
    localparam logic [SPR_W-1:0] SPREAD_CAP = SPR_W'(MAX_SPREAD);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_SETUP,
        ST_UPD,
        ST_DRAIN,
        ST_RDW,
        ST_PUSH
    } state_t;

    state_t state_reg;

    logic [SIZE_W-1:0]   bin_size_reg;
    logic [SPREAD_W-1:0] bin_spread_reg;
    logic [IDX_W-1:0]    clr_cnt_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [SPR_W-1:0]    spread_reg;
    logic [31:0]         q_reg;
    logic [32:0]         cur_reg;
    logic [32:0]         hi_reg;
    logic                drop_reg;
    logic                sat_reg;
    logic [SUM_W-1:0]    value_reg;
    logic                is_add_reg;
    logic [IDX_OUT_W-1:0] rd_idx_reg;
    logic                rd_hit_reg;
    logic                clr_req_reg;
    logic                p_valid_reg;
    logic [IDX_W-1:0]    p_addr_reg;
    logic                p_center_reg;
    logic                m_valid_reg;
    shb_out_t            m_payload_reg;

    logic                s_fire;
    logic                in_is_add;
    logic                rd_in_range;
    logic                issue_in_range;
    logic [SPR_W-1:0]    spread_eff;
    logic [31:0]         divisor;
    logic                div_start;
    logic                div_done;
    shb_div_res_t        div_res;
    logic [31:0]         q_adj;
    logic [32:0]         spread_ext;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [SUM_W-1:0]    ram_wdata;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;
    logic [SUM_W-1:0]    ram_rdata;
    logic [SUM_W:0]      sum;
    logic                sum_ovf;
    logic [SUM_W-1:0]    sum_sat;
    shb_out_t            res;

    assign s_ready        = (state_reg == ST_IDLE);
    assign s_fire         = s_valid && s_ready;
    assign in_is_add      = (s_payload.mode == MODE_ADD);
    assign rd_in_range    = (33'(s_payload.bin_index) < NUM_BINS_W);
    assign issue_in_range = (cur_reg < NUM_BINS_W);
    assign spread_eff     = (8'(bin_spread_reg) > 8'(MAX_SPREAD)) ? SPREAD_CAP
                                                                  : SPR_W'(bin_spread_reg);
    assign divisor        = (bin_size_reg == '0) ? 32'd1 : bin_size_reg;
    assign div_start      = s_fire && in_is_add;
    assign q_adj          = (div_res.quotient != '0 && div_res.exact)
                            ? div_res.quotient - 32'd1 : div_res.quotient;
    assign spread_ext     = 33'(spread_reg);

    shb_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (s_payload.peak_position),
        .divisor  (divisor),
        .done     (div_done),
        .result   (div_res)
    );

    // saturating add of the weight onto the bin just read
    assign sum     = {1'b0, ram_rdata} + (SUM_W+1)'(weight_reg);
    assign sum_ovf = sum[SUM_W];
    assign sum_sat = sum_ovf ? SUM_MAX : sum[SUM_W-1:0];

    assign ram_re    = (s_fire && !in_is_add && rd_in_range)
                       || (state_reg == ST_UPD && issue_in_range);
    assign ram_raddr = (state_reg == ST_UPD) ? IDX_W'(cur_reg)
                                             : IDX_W'(s_payload.bin_index);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = p_addr_reg;
        ram_wdata = sum_sat;
        priority if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end else if (p_valid_reg) begin
            ram_we = 1'b1;
        end else if (state_reg == ST_RDW && rd_hit_reg && clr_req_reg) begin
            ram_we    = 1'b1;
            ram_waddr = IDX_W'(rd_idx_reg);
            ram_wdata = '0;
        end
    end

    shb_ram #(
        .DEPTH  (NUM_BINS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        res.bin_value = value_reg;
        if (is_add_reg) begin
            res.center_bin = (q_reg > 32'(CENTER_MAX)) ? CENTER_MAX : q_reg[IDX_OUT_W-1:0];
            res.status     = sat_reg ? STAT_SAT : (drop_reg ? STAT_DROP : STAT_OK);
        end else begin
            res.center_bin = rd_idx_reg;
            res.status     = rd_hit_reg ? STAT_OK : STAT_DROP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
            p_valid_reg    <= 1'b0;
            bin_size_reg   <= BIN_SIZE_RESET;
            bin_spread_reg <= BIN_SPREAD_RESET;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_BIN_SIZE) begin
                    bin_size_reg <= cfg_wdata;
                end else begin
                    bin_spread_reg <= cfg_wdata[SPREAD_W-1:0];
                end
            end

            // update pipeline: read issued in UPD, written back in the cycle after
            p_valid_reg  <= (state_reg == ST_UPD) && issue_in_range;
            p_addr_reg   <= IDX_W'(cur_reg);
            p_center_reg <= (cur_reg == 33'(q_reg));
            if (p_valid_reg) begin
                if (sum_ovf) begin
                    sat_reg <= 1'b1;
                end
                if (p_center_reg) begin
                    value_reg <= sum_sat;
                end
            end

            if (m_valid_reg && m_ready && state_reg != ST_PUSH) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
                    if (clr_cnt_reg == LAST_BIN) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_fire) begin
                        is_add_reg <= in_is_add;
                        rd_idx_reg <= s_payload.bin_index;
                        if (in_is_add) begin
                            weight_reg <= s_payload.peak_weight;
                            spread_reg <= spread_eff;
                            drop_reg   <= 1'b0;
                            sat_reg    <= 1'b0;
                            value_reg  <= '0;
                            state_reg  <= ST_DIV;
                        end else begin
                            rd_hit_reg  <= rd_in_range;
                            clr_req_reg <= (s_payload.mode == MODE_READ_CLR);
                            state_reg   <= ST_RDW;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        q_reg     <= q_adj;
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    cur_reg   <= (33'(q_reg) >= spread_ext) ? 33'(q_reg) - spread_ext : '0;
                    hi_reg    <= 33'(q_reg) + spread_ext;
                    state_reg <= ST_UPD;
                end
                ST_UPD: begin
                    if (!issue_in_range) begin
                        drop_reg <= 1'b1;
                    end
                    cur_reg <= cur_reg + 33'd1;
                    if (cur_reg == hi_reg) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_PUSH;
                end
                ST_RDW: begin
                    value_reg <= rd_hit_reg ? ram_rdata : '0;
                    state_reg <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_payload_reg <= res;
                        m_valid_reg   <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // write-back never collides with a read of the same bin
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("bin store read and write hit the same entry");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> (!s_ready && !p_valid_reg))
        else $error("transfer or update during the clearing sweep");

    a_update_only_on_add: assert property (@(posedge aclk) disable iff (!aresetn)
        p_valid_reg |-> is_add_reg)
        else $error("bin update outside an add");

endmodule

// ===== src/shb_divider.sv =====
// shb_divider: restoring divider, one quotient bit per cycle
// 32-bit unsigned quotient plus an exact-division flag
// depends on shb_pkg
module shb_divider (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [31:0]           dividend,
    input  logic [31:0]           divisor,
    output logic                  done,
    output shb_pkg::shb_div_res_t result
);
    import shb_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] dvs_reg;
    logic [32:0] rem_shift;
    logic        ge;

    assign rem_shift = {rem_reg, quo_reg[31]};
    assign ge        = rem_shift >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == 5'd31);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= ge ? 32'(rem_shift - {1'b0, dvs_reg}) : rem_shift[31:0];
                quo_reg <= {quo_reg[30:0], ge};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done            = done_reg;
    assign result.quotient = quo_reg;
    assign result.exact    = (rem_reg == '0);

endmodule

// ===== src/shb_ram.sv =====
// shb_ram: bin store, one write port and one read port
// read data registered; depends on shb_pkg
module shb_ram #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [ADDR_W-1:0]        waddr,
    input  logic [shb_pkg::SUM_W-1:0] wdata,
    input  logic                     re,
    input  logic [ADDR_W-1:0]        raddr,
    output logic [shb_pkg::SUM_W-1:0] rdata
);
    import shb_pkg::*;

    logic [SUM_W-1:0] mem [DEPTH];
    logic [SUM_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== dv/shb_bin_checker.sv =====
// shb_bin_checker: watches the request, result and register ports of the binner
// keeps its own copy of the bin store and registers, compares every result in order
// depends on shb_pkg
module shb_bin_checker #(
    parameter int NUM_BINS   = 4096,
    parameter int MAX_SPREAD = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  shb_pkg::shb_in_t                s_payload,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  shb_pkg::shb_out_t               m_payload,
    input  logic                            cfg_we,
    input  logic [shb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [shb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                              mismatch_count,
    output int                              pending_count
);
    import shb_pkg::*;

    logic [SUM_W-1:0]    bin_sums [NUM_BINS];
    logic [SIZE_W-1:0]   bin_size_copy;
    logic [SPREAD_W-1:0] bin_spread_copy;
    logic                spill;
    logic                clipped;
    shb_out_t            bin_reports_due [$];

    function automatic void deposit(logic [33:0] idx, logic [WEIGHT_W-1:0] wt);
        logic [SUM_W:0] total;
        if (idx >= NUM_BINS) begin
            spill = 1'b1;
        end else begin
            total = {1'b0, bin_sums[idx]} + (SUM_W+1)'(wt);
            if (total > {1'b0, SUM_MAX}) begin
                total = {1'b0, SUM_MAX};
                clipped = 1'b1;
            end
            bin_sums[idx] = total[SUM_W-1:0];
        end
    endfunction

    function automatic shb_out_t bin_report_for(shb_in_t item);
        shb_out_t    rep;
        logic [32:0] width;
        logic [33:0] q;
        int          reach;
        rep = '0;
        if (item.mode == MODE_ADD) begin
            width = (bin_size_copy == '0) ? 33'd1 : {1'b0, bin_size_copy};
            reach = (bin_spread_copy > MAX_SPREAD) ? MAX_SPREAD : int'(bin_spread_copy);
            q = {2'b00, item.peak_position} / width;
            // exact multiples land one bin lower, except position zero
            if (q != 0 && ({1'b0, item.peak_position} % width) == 0)
                q = q - 1;
            spill = 1'b0;
            clipped = 1'b0;
            deposit(q, item.peak_weight);
            for (int j = 1; j <= reach; j++) begin
                deposit(q + j, item.peak_weight);
                if (q >= j)
                    deposit(q - j, item.peak_weight);
            end
            if (q < NUM_BINS)
                rep.bin_value = bin_sums[q];
            rep.center_bin = (q > CENTER_MAX) ? CENTER_MAX : q[IDX_OUT_W-1:0];
            rep.status = clipped ? STAT_SAT : (spill ? STAT_DROP : STAT_OK);
        end else begin
            rep.center_bin = item.bin_index;
            if (item.bin_index < NUM_BINS) begin
                rep.bin_value = bin_sums[item.bin_index];
                if (item.mode == MODE_READ_CLR)
                    bin_sums[item.bin_index] = '0;
            end else begin
                rep.status = STAT_DROP;
            end
        end
        return rep;
    endfunction

    always @(posedge aclk) begin : watch
        shb_out_t want;
        if (!aresetn) begin
            foreach (bin_sums[i])
                bin_sums[i] = '0;
            bin_size_copy = BIN_SIZE_RESET;
            bin_spread_copy = BIN_SPREAD_RESET;
            bin_reports_due.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_BIN_SIZE)
                    bin_size_copy = cfg_wdata[SIZE_W-1:0];
                else if (cfg_index == REG_BIN_SPREAD)
                    bin_spread_copy = cfg_wdata[SPREAD_W-1:0];
            end
            if (s_valid && s_ready)
                bin_reports_due.push_back(bin_report_for(s_payload));
            if (m_valid && m_ready) begin
                if (bin_reports_due.size() == 0) begin
                    $error("result transfer with nothing pending");
                    mismatch_count++;
                end else begin
                    want = bin_reports_due.pop_front();
                    if (m_payload.bin_value !== want.bin_value) begin
                        $error("bin_value: expected %0h, got %0h",
                               want.bin_value, m_payload.bin_value);
                        mismatch_count++;
                    end
                    if (m_payload.center_bin !== want.center_bin) begin
                        $error("center_bin: expected %0d, got %0d",
                               want.center_bin, m_payload.center_bin);
                        mismatch_count++;
                    end
                    if (m_payload.status !== want.status) begin
                        $error("status: expected %0d, got %0d",
                               want.status, m_payload.status);
                        mismatch_count++;
                    end
                end
            end
        end
        pending_count = bin_reports_due.size();
    end

endmodule

// ===== dv/testbench.sv =====
// testbench: drives peaks, reads and register writes into the histogram binner
// directed corner items, then random phases over several bin sizes and spreads
// depends on shb_pkg, spread_histogram_binner_core, shb_bin_checker
module testbench;
    import shb_pkg::*;

    localparam logic [1:0] MODE_READ_ALT = 2'd3;
    localparam int NUM_BINS   = 4096;
    localparam int MAX_SPREAD = 8;
    localparam int HOLD_OFF_CYCLES = 400;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    shb_in_t               s_payload = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    shb_out_t              m_payload;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int          mismatch_count;
    int          pending_count;
    bit          quiet_tx = 1'b0;
    bit          quiet_rx = 1'b0;
    bit          hold_off_req = 1'b0;
    logic [31:0] cur_size = BIN_SIZE_RESET;

    always #6 aclk = ~aclk;

    spread_histogram_binner_core #(
        .NUM_BINS   (NUM_BINS),
        .MAX_SPREAD (MAX_SPREAD)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    shb_bin_checker #(
        .NUM_BINS   (NUM_BINS),
        .MAX_SPREAD (MAX_SPREAD)
    ) bin_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload      (s_payload),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload      (m_payload),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_item(logic [1:0] mode, logic [31:0] pos, logic [23:0] wt,
                             logic [11:0] idx);
        shb_in_t item;
        int      gap;
        item.mode = mode;
        item.peak_position = pos;
        item.peak_weight = wt;
        item.bin_index = idx;
        @(negedge aclk);
        gap = quiet_tx ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_payload <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge aclk);
    endtask

    // positions at bin edges or anywhere within a bin of the current size, low bins favored
    function automatic logic [31:0] pick_position();
        logic [63:0] width;
        logic [63:0] k;
        logic [63:0] p;
        int          r;
        width = (cur_size == 0) ? 64'd1 : {32'd0, cur_size};
        r = $urandom_range(0, 9);
        if (r == 0)
            return $urandom;
        k = (r < 7) ? 64'($urandom_range(0, 40)) : 64'($urandom_range(0, 4100));
        p = k * width;
        if ($urandom_range(0, 2) != 0)
            p = p + ({32'd0, $urandom} % width);
        return p[31:0];
    endfunction

    task automatic send_random_item();
        logic [1:0]  mode;
        logic [23:0] wt;
        logic [11:0] idx;
        int          r;
        r = $urandom_range(0, 19);
        if (r < 12)
            mode = MODE_ADD;
        else if (r < 15)
            mode = MODE_READ;
        else if (r < 19)
            mode = MODE_READ_CLR;
        else
            mode = MODE_READ_ALT;
        r = $urandom_range(0, 9);
        if (r < 2)
            wt = 24'hFFFFFF;
        else if (r < 5)
            wt = 24'($urandom_range(0, 255));
        else
            wt = 24'($urandom);
        idx = ($urandom_range(0, 9) < 7) ? 12'($urandom_range(0, 48)) : 12'($urandom);
        send_item(mode, pick_position(), wt, idx);
    endtask

    task automatic run_phase(logic [31:0] size, logic [31:0] spread, int count,
                             bit tx_still, bit rx_still, bit long_hold);
        drain();
        write_reg(REG_BIN_SIZE, size);
        write_reg(REG_BIN_SPREAD, spread);
        cur_size = size;
        quiet_tx = tx_still;
        quiet_rx = rx_still;
        @(posedge aclk);
        hold_off_req = long_hold;
        repeat (count)
            send_random_item();
    endtask

    // result side
    initial begin : result_sink
        int gap;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end
            gap = quiet_rx ? 0 : $urandom_range(0, 15);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin : stimulus
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // reset configuration: size 2.0, spread 1
        send_item(MODE_ADD, 32'd0, 24'hFFFFFF, 12'd0);
        send_item(MODE_ADD, 32'd131072, 24'd1, 12'hFFF);
        send_item(MODE_ADD, 32'd131073, 24'h000010, 12'd0);
        send_item(MODE_ADD, 32'hFFFFFFFF, 24'hABCDEF, 12'hFFF);
        send_item(MODE_ADD, 32'h1FFE0005, 24'd7, 12'd0);
        send_item(MODE_READ, 32'hFFFFFFFF, 24'hFFFFFF, 12'd0);
        send_item(MODE_READ, 32'd0, 24'd0, 12'd1);
        send_item(MODE_READ_CLR, 32'd0, 24'd0, 12'd1);
        send_item(MODE_READ, 32'd0, 24'd0, 12'd1);
        send_item(MODE_READ_ALT, 32'd0, 24'd0, 12'hFFF);
        send_item(MODE_READ_CLR, 32'd0, 24'd0, 12'hFFF);

        // zero size acts as the smallest width, spread clipped to its maximum
        drain();
        write_reg(REG_BIN_SIZE, 32'd0);
        write_reg(REG_BIN_SPREAD, 32'd15);
        cur_size = 32'd0;
        send_item(MODE_ADD, 32'd5, 24'd3, 12'd0);
        send_item(MODE_ADD, 32'd0, 24'hFFFFFF, 12'd0);
        send_item(MODE_ADD, 32'd4096, 24'd9, 12'd0);
        send_item(MODE_ADD, 32'd4104, 24'd2, 12'd0);
        send_item(MODE_READ_ALT, 32'd0, 24'd0, 12'd4);
        send_item(MODE_READ_CLR, 32'd0, 24'd0, 12'd0);

        // widest bins, no spread
        drain();
        write_reg(REG_BIN_SIZE, 32'hFFFFFFFF);
        write_reg(REG_BIN_SPREAD, 32'd0);
        cur_size = 32'hFFFFFFFF;
        send_item(MODE_ADD, 32'hFFFFFFFF, 24'd1, 12'd0);
        send_item(MODE_ADD, 32'hFFFFFFFE, 24'd1, 12'd0);
        send_item(MODE_READ_CLR, 32'd0, 24'd0, 12'd0);
        send_item(MODE_READ, 32'd0, 24'd0, 12'hFFF);

        run_phase(32'd65536, 32'd2, 250, 1'b0, 1'b0, 1'b0);
        run_phase(32'd1, 32'd8, 250, 1'b1, 1'b0, 1'b1);
        run_phase($urandom_range(1 << 10, 1 << 20), $urandom_range(0, 15), 250,
                  1'b0, 1'b1, 1'b0);
        run_phase(32'hFFFFFFFF, 32'd15, 250, 1'b1, 1'b1, 1'b0);
        run_phase(32'd0, 32'd0, 250, 1'b0, 1'b0, 1'b0);
        run_phase($urandom, $urandom_range(0, 15), 250, 1'b0, 1'b0, 1'b0);

        drain();
        repeat (60) @(negedge aclk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin : watchdog
        #(12 * 800000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/shb_pkg.sv
src/shb_divider.sv
src/shb_ram.sv
src/spread_histogram_binner_core.sv
dv/shb_bin_checker.sv
dv/testbench.sv
